### rtl/core/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the shooter feed sequencer
// Word layouts, register map, reset values and the structs that connect the
// loader, the friction filter and the top level.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_HOLD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_HOLD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_HOLD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_RC    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPD  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE   = 4'd7;

    // Register reset values
    localparam logic [15:0] RST_SINGLE_HOLD  = 16'd1000;
    localparam logic [15:0] RST_TRIPLE_HOLD  = 16'd500;
    localparam logic [15:0] RST_BACKOFF_HOLD = 16'd400;
    localparam logic [23:0] RST_FILTER_RC    = 24'd200000;
    localparam logic [15:0] RST_FAST_SPEED   = 16'd40000;
    localparam logic [15:0] RST_DEFAULT_SPD  = 16'd40000;
    localparam logic [15:0] RST_STEP_ANGLE   = 16'd1620;
    localparam logic [15:0] RST_RATE_SCALE   = 16'd1620;

    // Load modes
    localparam logic [2:0] MODE_STOP    = 3'd0;
    localparam logic [2:0] MODE_SINGLE  = 3'd1;
    localparam logic [2:0] MODE_TRIPLE  = 3'd2;
    localparam logic [2:0] MODE_BURST   = 3'd3;
    localparam logic [2:0] MODE_REVERSE = 3'd4;

    // Bullet speed classes with a configured friction target
    localparam logic [1:0] CLASS_FAST    = 2'd2;
    localparam logic [1:0] CLASS_DEFAULT = 2'd3;

    typedef struct packed {
        logic [15:0] single_hold_ms;
        logic [15:0] triple_hold_ms;
        logic [15:0] backoff_hold_ms;
        logic [23:0] filter_rc_us;
        logic [15:0] fast_class_speed;
        logic [15:0] default_class_speed;
        logic [15:0] bullet_step_angle;
        logic [15:0] rate_to_speed_scale;
    } cfg_t;

    typedef struct packed {
        logic               shooter_on;
        logic [2:0]         feed_mode;
        logic               wheel_run;
        logic [1:0]         speed_class;
        logic signed [7:0]  fire_rate;
        logic signed [31:0] loader_angle;
        logic [31:0]        time_ms;
        logic [19:0]        interval_us;
    } in_t;

    typedef struct packed {
        logic               motors_enabled;
        logic               loader_update;
        logic               loader_speed_loop;
        logic signed [31:0] loader_reference;
        logic [15:0]        friction_reference;
        logic               shooter_ready;
    } out_t;

    // Loader part of one result
    typedef struct packed {
        logic               motors_enabled;
        logic               loader_update;
        logic               loader_speed_loop;
        logic signed [31:0] loader_reference;
        logic               shooter_ready;
    } loader_res_t;

    typedef struct packed {
        logic start;
        logic ack;
    } filt_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } filt_stat_t;

endpackage

### rtl/core/shooter_feed_sequencer.sv
// ----------------------------------------------------------------------------
// shooter_feed_sequencer: loader sequencing and friction target filtering
// Takes one control tick per word, sequences the loader (back-off, single,
// triple, burst, reverse) and smooths the friction wheel target with a
// first-order low-pass filter kept in unsigned Q16.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Word
//   --------+--------------------------------+-----------------------------
//   input   | s_valid, s_ready, s_data       | sfs_pkg::in_t, one tick
//   result  | m_valid, m_ready, m_data       | sfs_pkg::out_t, one per tick
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Flow: the result shows on m_valid and s_ready rises again only once the
//   filter has run its products, its sum and its 32-step restoring divider,
//   so a new tick is not taken before the last one is through; with a zero
//   filter denominator the divider is skipped.
// Reset: aresetn is synchronous, active low; it loads the register reset
//   values, clears loader state and the filter state, and empties m_valid.
// Stalls: a finished result waits in the output register while the next
//   tick is taken; a second result waits in the filter until the first leaves.
// Config writes are always taken (cfg_ready high); indexes past the map drop.
// ----------------------------------------------------------------------------
module shooter_feed_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sfs_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sfs_pkg::out_t                  m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfs_pkg::*;

    cfg_t        cfg_reg;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg;

    logic        accept;
    logic        out_load;
    filt_ctrl_t  filt_ctrl;
    filt_stat_t  filt_stat;
    loader_res_t loader_res;
    logic [15:0] friction_ref;

    // Take a new tick only when the filter sequencer is free
    assign s_ready   = filt_stat.idle;
    assign accept    = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    // Move a finished result into the output register when it is free
    assign out_load  = filt_stat.done & (~m_valid_reg | m_ready);

    assign filt_ctrl.start = accept;
    assign filt_ctrl.ack   = out_load;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.single_hold_ms      <= RST_SINGLE_HOLD;
            cfg_reg.triple_hold_ms      <= RST_TRIPLE_HOLD;
            cfg_reg.backoff_hold_ms     <= RST_BACKOFF_HOLD;
            cfg_reg.filter_rc_us        <= RST_FILTER_RC;
            cfg_reg.fast_class_speed    <= RST_FAST_SPEED;
            cfg_reg.default_class_speed <= RST_DEFAULT_SPD;
            cfg_reg.bullet_step_angle   <= RST_STEP_ANGLE;
            cfg_reg.rate_to_speed_scale <= RST_RATE_SCALE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SINGLE_HOLD:  cfg_reg.single_hold_ms      <= cfg_data[15:0];
                CFG_TRIPLE_HOLD:  cfg_reg.triple_hold_ms      <= cfg_data[15:0];
                CFG_BACKOFF_HOLD: cfg_reg.backoff_hold_ms     <= cfg_data[15:0];
                CFG_FILTER_RC:    cfg_reg.filter_rc_us        <= cfg_data[23:0];
                CFG_FAST_SPEED:   cfg_reg.fast_class_speed    <= cfg_data[15:0];
                CFG_DEFAULT_SPD:  cfg_reg.default_class_speed <= cfg_data[15:0];
                CFG_STEP_ANGLE:   cfg_reg.bullet_step_angle   <= cfg_data[15:0];
                CFG_RATE_SCALE:   cfg_reg.rate_to_speed_scale <= cfg_data[15:0];
                default: begin
                    // drop writes past the register map
                end
            endcase
        end
    end

    // Loader: decides and registers its fields at acceptance
    sfs_loader u_loader (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .item    (s_data),
        .cfg     (cfg_reg),
        .res     (loader_res)
    );

    // Friction filter: multi-cycle, signals done when its state is updated or held
    sfs_filter u_filter (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl               (filt_ctrl),
        .item               (s_data),
        .cfg                (cfg_reg),
        .stat               (filt_stat),
        .friction_reference (friction_ref)
    );

    // Output register: hold until taken, advance on load
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.motors_enabled     <= loader_res.motors_enabled;
            m_data_reg.loader_update      <= loader_res.loader_update;
            m_data_reg.loader_speed_loop  <= loader_res.loader_speed_loop;
            m_data_reg.loader_reference   <= loader_res.loader_reference;
            m_data_reg.friction_reference <= friction_ref;
            m_data_reg.shooter_ready      <= loader_res.shooter_ready;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/core/sfs_loader.sv
// ----------------------------------------------------------------------------
// sfs_loader: loader mode sequencing
// Back-off arming, shot hold-off timing, angle and speed targets. State and
// the loader result fields are registered when a word is taken.
// ----------------------------------------------------------------------------
module sfs_loader (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  sfs_pkg::in_t         item,
    input  sfs_pkg::cfg_t        cfg,
    output sfs_pkg::loader_res_t res
);
    import sfs_pkg::*;

    logic [2:0]         prev_mode_reg, prev_mode_next;
    logic               backoff_done_reg, backoff_done_next;
    logic               primed_reg, primed_next;
    logic [31:0]        hold_start_reg, hold_start_next;
    logic [15:0]        hold_len_reg, hold_len_next;
    loader_res_t        res_reg, res_next;

    logic               held;
    logic               upd;
    logic               spd;
    logic signed [33:0] angle_s;
    logic signed [33:0] step_s;
    logic signed [24:0] speed_prod;
    logic signed [33:0] ref_wide;
    logic [31:0]        ref_sat;

    assign held    = ({1'b0, hold_start_reg} + {17'b0, hold_len_reg}) > {1'b0, item.time_ms};
    assign angle_s = 34'(item.loader_angle);
    assign step_s  = $signed({18'b0, cfg.bullet_step_angle});
    assign speed_prod = item.fire_rate * $signed({1'b0, cfg.rate_to_speed_scale});

    always_comb begin
        prev_mode_next    = item.feed_mode;
        backoff_done_next = backoff_done_reg;
        primed_next       = primed_reg;
        hold_start_next   = hold_start_reg;
        hold_len_next     = hold_len_reg;
        upd               = 1'b0;
        spd               = 1'b0;
        ref_wide          = '0;

        // Leaving stop arms the back-off
        if ((item.feed_mode != MODE_STOP) && (prev_mode_reg == MODE_STOP)) begin
            backoff_done_next = 1'b0;
        end

        case (item.feed_mode)
            MODE_STOP: begin
                if (!backoff_done_next) begin
                    upd               = 1'b1;
                    ref_wide          = angle_s - step_s;
                    backoff_done_next = 1'b1;
                    primed_next       = 1'b0;
                    hold_start_next   = item.time_ms;
                    hold_len_next     = cfg.backoff_hold_ms;
                end
            end
            MODE_SINGLE: begin
                if (!held) begin
                    upd             = 1'b1;
                    ref_wide        = primed_reg ? angle_s + step_s
                                                 : angle_s + (step_s <<< 1);
                    primed_next     = 1'b1;
                    hold_start_next = item.time_ms;
                    hold_len_next   = cfg.single_hold_ms;
                end
            end
            MODE_TRIPLE: begin
                if (!held) begin
                    upd             = 1'b1;
                    ref_wide        = angle_s + step_s + (step_s <<< 1);
                    hold_start_next = item.time_ms;
                    hold_len_next   = cfg.triple_hold_ms;
                end
            end
            MODE_BURST, MODE_REVERSE: begin
                upd      = 1'b1;
                spd      = 1'b1;
                ref_wide = 34'(speed_prod);
            end
            default: begin
                upd = 1'b0;
            end
        endcase

        // Saturate to the signed 32-bit range
        if ((ref_wide[33:31] == 3'b000) || (ref_wide[33:31] == 3'b111)) begin
            ref_sat = ref_wide[31:0];
        end else if (ref_wide[33]) begin
            ref_sat = 32'h8000_0000;
        end else begin
            ref_sat = 32'h7FFF_FFFF;
        end

        res_next.motors_enabled    = item.shooter_on;
        res_next.loader_update     = upd;
        res_next.loader_speed_loop = upd & spd;
        res_next.loader_reference  = upd ? ref_sat : '0;
        res_next.shooter_ready     = item.wheel_run;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mode_reg    <= MODE_STOP;
            backoff_done_reg <= 1'b1;
            primed_reg       <= 1'b0;
            hold_start_reg   <= '0;
            hold_len_reg     <= '0;
        end else if (start) begin
            prev_mode_reg    <= prev_mode_next;
            backoff_done_reg <= backoff_done_next;
            primed_reg       <= primed_next;
            hold_start_reg   <= hold_start_next;
            hold_len_reg     <= hold_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/sfs_filter.sv
// ----------------------------------------------------------------------------
// sfs_filter: friction target low-pass filter
// One shared multiplier and one shared compare-subtract stage under a small
// sequencer: two products, one sum, then a 32-step restoring division.
// ----------------------------------------------------------------------------
module sfs_filter (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfs_pkg::filt_ctrl_t ctrl,
    input  sfs_pkg::in_t        item,
    input  sfs_pkg::cfg_t       cfg,
    output sfs_pkg::filt_stat_t stat,
    output logic [15:0]         friction_reference
);
    import sfs_pkg::*;

    localparam int DivSteps = 32;
    localparam int CntW     = $clog2(DivSteps);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [15:0]       target_reg;
    logic [19:0]       dt_reg;
    logic [24:0]       den_reg;
    logic [55:0]       prod_reg;
    logic [55:0]       acc_reg;
    logic [24:0]       rem_reg;
    logic [DivSteps-1:0] quot_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [31:0]       filt_reg;

    logic [15:0]       target_sel;
    logic [31:0]       mul_a;
    logic [23:0]       mul_b;
    logic [55:0]       mul_p;
    logic [56:0]       num;
    logic [25:0]       shifted;
    logic [25:0]       diff;
    logic              fit;

    always_comb begin
        target_sel = '0;
        if (item.wheel_run) begin
            if (item.speed_class == CLASS_FAST) begin
                target_sel = cfg.fast_class_speed;
            end else if (item.speed_class == CLASS_DEFAULT) begin
                target_sel = cfg.default_class_speed;
            end
        end
    end

    // Shared multiplier: target times interval, then old state times rc
    always_comb begin
        if (state_reg == ST_MUL_A) begin
            mul_a = {target_reg, 16'h0000};
            mul_b = {4'h0, dt_reg};
        end else begin
            mul_a = filt_reg;
            mul_b = cfg.filter_rc_us;
        end
    end

    assign mul_p   = 56'(mul_a) * 56'(mul_b);
    assign num     = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign shifted = {rem_reg, quot_reg[DivSteps-1]};
    assign fit     = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            filt_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (ctrl.start) begin
                        target_reg <= target_sel;
                        dt_reg     <= item.interval_us;
                        den_reg    <= {1'b0, cfg.filter_rc_us} + {5'b0, item.interval_us};
                        state_reg  <= ST_MUL_A;
                    end
                end
                ST_MUL_A: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    // Zero denominator: hold the filter state
                    if (den_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        rem_reg   <= num[56:32];
                        quot_reg  <= num[31:0];
                        cnt_reg   <= CntW'(DivSteps - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= fit ? diff[24:0] : shifted[24:0];
                    quot_reg <= {quot_reg[DivSteps-2:0], fit};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        filt_reg  <= {quot_reg[DivSteps-2:0], fit};
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (ctrl.ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.idle          = (state_reg == ST_IDLE);
    assign stat.done          = (state_reg == ST_DONE);
    assign friction_reference = filt_reg[31:16];

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> state_reg == ST_IDLE)
        else $error("filter started while busy");

    a_start_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |=> state_reg == ST_MUL_A)
        else $error("filter did not begin after start");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("division remainder out of range");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && !ctrl.ack |=> (state_reg == ST_DONE) && $stable(filt_reg))
        else $error("finished filter result not held");

endmodule

### test/tb_shooter_feed_sequencer.sv
// ----------------------------------------------------------------------------
// tb_shooter_feed_sequencer: self-checking bench for the shooter feed sequencer
// Drives control ticks, register writes and result back-pressure, predicts
// every result word, and compares each field in arrival order. The loader
// sequencing (back-off, single, triple, burst, reverse, hold-off) and the Q16
// friction filter are predicted here.
// ----------------------------------------------------------------------------
module tb_shooter_feed_sequencer;
    import sfs_pkg::*;

    // Load modes past reverse leave the loader alone.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    // Speed classes with a fixed zero friction target.
    localparam logic [1:0] CLASS_15MS = 2'd0;
    localparam logic [1:0] CLASS_18MS = 2'd1;

    localparam int SETTLE_CYCLES    = 45;    // longer than one tick takes end to end
    localparam int LONG_HOLD_CYCLES = 400;   // result side hold-off for back-pressure
    localparam int MAX_REPORTS      = 10;

    // ------------------------------------------------------------------------
    // Expected-result ledger: a cycle-free copy of the sequencer and filter.
    // ------------------------------------------------------------------------
    class feed_ledger;
        // register copy
        logic [15:0] single_hold, triple_hold, backoff_hold;
        logic [23:0] filter_rc;
        logic [15:0] fast_speed, default_speed, pitch, rate_scale;
        // sequencer state
        logic [2:0]  prev_mode;
        bit          backoff_done, primed;
        logic [31:0] hold_start;
        logic [15:0] hold_len;
        logic [31:0] filt_q16;

        out_t        expected_results[$];
        int          mismatches, results_seen;
        int          angle_shots, speed_sets, backoffs, held_shots, clipped, frozen_filter;

        function new();
            single_hold   = RST_SINGLE_HOLD;
            triple_hold   = RST_TRIPLE_HOLD;
            backoff_hold  = RST_BACKOFF_HOLD;
            filter_rc     = RST_FILTER_RC;
            fast_speed    = RST_FAST_SPEED;
            default_speed = RST_DEFAULT_SPD;
            pitch         = RST_STEP_ANGLE;
            rate_scale    = RST_RATE_SCALE;
            prev_mode     = MODE_STOP;
            backoff_done  = 1'b1;
            primed        = 1'b0;
            hold_start    = '0;
            hold_len      = '0;
            filt_q16      = '0;
        endfunction

        // Mirror one register write; indexes past the map drop.
        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SINGLE_HOLD:  single_hold   = val[15:0];
                CFG_TRIPLE_HOLD:  triple_hold   = val[15:0];
                CFG_BACKOFF_HOLD: backoff_hold  = val[15:0];
                CFG_FILTER_RC:    filter_rc     = val;
                CFG_FAST_SPEED:   fast_speed    = val[15:0];
                CFG_DEFAULT_SPD:  default_speed = val[15:0];
                CFG_STEP_ANGLE:   pitch         = val[15:0];
                CFG_RATE_SCALE:   rate_scale    = val[15:0];
                default: ;
            endcase
        endfunction

        // Predict the result of one accepted tick and queue it.
        function void note_tick(in_t t);
            out_t        r;
            logic [32:0] hold_end;
            bit          held;
            longint      aim, stride;
            logic [63:0] target, den, num;
            r      = '0;
            aim    = 0;
            target = '0;
            stride = longint'(pitch);
            // hold-off end is summed one bit wider, so it never wraps
            hold_end = {1'b0, hold_start} + {17'b0, hold_len};
            held     = hold_end > {1'b0, t.time_ms};

            if (t.feed_mode != MODE_STOP && prev_mode == MODE_STOP) backoff_done = 1'b0;
            prev_mode = t.feed_mode;

            case (t.feed_mode)
                MODE_STOP: begin
                    if (!backoff_done) begin
                        r.loader_update = 1'b1;
                        aim             = longint'(t.loader_angle) - stride;
                        backoff_done    = 1'b1;
                        primed          = 1'b0;
                        hold_start      = t.time_ms;
                        hold_len        = backoff_hold;
                        backoffs++;
                    end
                end
                MODE_SINGLE: begin
                    if (!held) begin
                        r.loader_update = 1'b1;
                        aim        = longint'(t.loader_angle) + (primed ? stride : 2 * stride);
                        primed     = 1'b1;
                        hold_start = t.time_ms;
                        hold_len   = single_hold;
                        angle_shots++;
                    end else begin
                        held_shots++;
                    end
                end
                MODE_TRIPLE: begin
                    if (!held) begin
                        r.loader_update = 1'b1;
                        aim        = longint'(t.loader_angle) + 3 * stride;
                        hold_start = t.time_ms;
                        hold_len   = triple_hold;
                        angle_shots++;
                    end else begin
                        held_shots++;
                    end
                end
                MODE_BURST, MODE_REVERSE: begin
                    r.loader_update     = 1'b1;
                    r.loader_speed_loop = 1'b1;
                    aim = longint'(t.fire_rate) * longint'(rate_scale);
                    speed_sets++;
                end
                default: ;
            endcase

            // clip the loader target to the signed 32-bit range
            if (aim > 64'sh7FFF_FFFF) begin
                aim = 64'sh7FFF_FFFF;
                clipped++;
            end else if (aim < -64'sh8000_0000) begin
                aim = -64'sh8000_0000;
                clipped++;
            end
            if (r.loader_update) r.loader_reference = aim[31:0];

            if (t.wheel_run) begin
                if (t.speed_class == CLASS_FAST) target = 64'(fast_speed);
                else if (t.speed_class == CLASS_DEFAULT) target = 64'(default_speed);
            end
            den = 64'(filter_rc) + 64'(t.interval_us);
            if (den != 0) begin
                num      = (target << 16) * 64'(t.interval_us) + 64'(filt_q16) * 64'(filter_rc);
                filt_q16 = 32'(num / den);
            end else begin
                frozen_filter++;
            end

            r.motors_enabled     = t.shooter_on;
            r.friction_reference = filt_q16[31:16];
            r.shooter_ready      = t.wheel_run;
            expected_results.push_back(r);
        endfunction

        // Compare one result word with the oldest prediction.
        function void check_result(out_t got);
            out_t exp_r;
            bit   bad;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result word %0d arrived with nothing expected",
                             $realtime, results_seen);
                return;
            end
            exp_r = expected_results.pop_front();
            bad = (got.motors_enabled     !== exp_r.motors_enabled)
               || (got.loader_update      !== exp_r.loader_update)
               || (got.loader_speed_loop  !== exp_r.loader_speed_loop)
               || (got.loader_reference   !== exp_r.loader_reference)
               || (got.friction_reference !== exp_r.friction_reference)
               || (got.shooter_ready      !== exp_r.shooter_ready);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] result word %0d mismatch", $realtime, results_seen);
                    $display("  expected: en=%b upd=%b spd=%b ref=%0d fric=%0d rdy=%b",
                             exp_r.motors_enabled, exp_r.loader_update,
                             exp_r.loader_speed_loop, exp_r.loader_reference,
                             exp_r.friction_reference, exp_r.shooter_ready);
                    $display("  actual:   en=%b upd=%b spd=%b ref=%0d fric=%0d rdy=%b",
                             got.motors_enabled, got.loader_update,
                             got.loader_speed_loop, got.loader_reference,
                             got.friction_reference, got.shooter_ready);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b1;
    out_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    feed_ledger ledger = new();

    bit          calm;          // set for the closing phase: no idling at all
    bit          squeeze_req;   // ask the result side for one long hold-off
    logic [31:0] clock_ms;      // running control timeline for random ticks
    logic [2:0]  run_mode;
    int          run_left;
    int          ticks_sent;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    shooter_feed_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: sample at the rising edge, stall in bursts at the falling one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) ledger.check_result(m_data);
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze_req) begin
                // hold off long enough that the block backs up and stalls its input
                squeeze_req = 1'b0;
                m_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("[%0t] timeout with %0d result words outstanding",
                 $realtime, ledger.pending());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one tick word; hold it until taken, then note it. Start and end at
    // a falling edge so valid stays up between back-to-back words.
    task automatic send_tick(input in_t t);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        ledger.note_tick(t);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Write one register; the caller drops cfg_valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        ledger.apply_reg(idx, val);
        @(negedge aclk);
    endtask

    // Load a full register set, with junk in the unused upper data bits and a
    // stray write past the map first.
    task automatic program_regs(input cfg_t c);
        write_reg(CFG_IDX_W'($urandom_range(CFG_RATE_SCALE + 1, 2**CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom));
        write_reg(CFG_SINGLE_HOLD,  {8'($urandom), c.single_hold_ms});
        write_reg(CFG_TRIPLE_HOLD,  {8'($urandom), c.triple_hold_ms});
        write_reg(CFG_BACKOFF_HOLD, {8'($urandom), c.backoff_hold_ms});
        write_reg(CFG_FILTER_RC,    c.filter_rc_us);
        write_reg(CFG_FAST_SPEED,   {8'($urandom), c.fast_class_speed});
        write_reg(CFG_DEFAULT_SPD,  {8'($urandom), c.default_class_speed});
        write_reg(CFG_STEP_ANGLE,   {8'($urandom), c.bullet_step_angle});
        write_reg(CFG_RATE_SCALE,   {8'($urandom), c.rate_to_speed_scale});
        cfg_valid <= 1'b0;
    endtask

    // Drain every outstanding result, then let the pipeline go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic in_t mk_tick(input bit on, input logic [2:0] mode, input bit fric,
                                    input logic [1:0] cls, input logic signed [7:0] rate,
                                    input logic [31:0] angle, input logic [31:0] now,
                                    input logic [19:0] dt);
        in_t t;
        t.shooter_on   = on;
        t.feed_mode    = mode;
        t.wheel_run    = fric;
        t.speed_class  = cls;
        t.fire_rate    = rate;
        t.loader_angle = angle;
        t.time_ms      = now;
        t.interval_us  = dt;
        return t;
    endfunction

    function automatic cfg_t random_cfg(input int unsigned hold_max, input int unsigned rc_max);
        cfg_t c;
        c.single_hold_ms      = 16'($urandom_range(0, hold_max));
        c.triple_hold_ms      = 16'($urandom_range(0, hold_max));
        c.backoff_hold_ms     = 16'($urandom_range(0, hold_max));
        c.filter_rc_us        = 24'($urandom_range(1, rc_max));
        c.fast_class_speed    = 16'($urandom);
        c.default_class_speed = 16'($urandom);
        c.bullet_step_angle   = 16'($urandom);
        c.rate_to_speed_scale = 16'($urandom);
        return c;
    endfunction

    // Build one random tick: runs of one load mode on an advancing timeline,
    // with a few fully random words mixed in as noise.
    function automatic in_t random_tick(input int unsigned pace_ms);
        in_t          t;
        logic [127:0] raw;
        int unsigned  pick;
        if (run_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 22)      run_mode = MODE_STOP;
            else if (pick < 47) run_mode = MODE_SINGLE;
            else if (pick < 67) run_mode = MODE_TRIPLE;
            else if (pick < 79) run_mode = MODE_BURST;
            else if (pick < 91) run_mode = MODE_REVERSE;
            else run_mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            run_left = $urandom_range(1, 6);
        end
        run_left--;

        pick = $urandom_range(0, 99);
        if (pick < 2)       clock_ms = $urandom;
        else if (pick < 10) clock_ms = clock_ms + $urandom_range(0, 70000);
        else                clock_ms = clock_ms + $urandom_range(0, pace_ms);

        if ($urandom_range(0, 19) == 0) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            t   = raw[$bits(in_t)-1:0];
            return t;
        end

        t.shooter_on  = ($urandom_range(0, 7) != 0);
        t.feed_mode   = run_mode;
        t.wheel_run   = ($urandom_range(0, 4) != 0);
        t.speed_class = 2'($urandom_range(0, 3));
        t.fire_rate   = 8'($urandom);
        t.time_ms     = clock_ms;

        pick = $urandom_range(0, 9);
        if (pick < 8)
            t.loader_angle = 32'($urandom_range(0, 400000)) - 32'd200000;
        else if (pick < 9)
            t.loader_angle = $urandom;
        else if ($urandom_range(0, 1) != 0)
            t.loader_angle = 32'h7FFF_FFFF - 32'($urandom_range(0, 200000));
        else
            t.loader_angle = 32'h8000_0000 + 32'($urandom_range(0, 200000));

        pick = $urandom_range(0, 9);
        if (pick < 7)      t.interval_us = 20'($urandom_range(500, 1500));
        else if (pick < 9) t.interval_us = 20'($urandom);
        else               t.interval_us = ($urandom_range(0, 1) != 0) ? '1 : '0;
        return t;
    endfunction

    task automatic run_random(input int count, input int unsigned pace_ms);
        for (int i = 0; i < count; i++) send_tick(random_tick(pace_ms));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_t c;
        clock_ms = '0;
        run_mode = MODE_STOP;
        run_left = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed ticks on the reset register values (step 1620, holds
        // 1000/500/400). Idle stop, then leaving stop arms the back-off.
        send_tick(mk_tick(0, MODE_STOP,   0, CLASS_15MS,    8'sd0, 32'd0,    32'd0,    20'd1000));
        // first single shot after reset is unprimed: two steps
        send_tick(mk_tick(1, MODE_SINGLE, 1, CLASS_FAST,    8'sd0, 32'd1000, 32'd10,   20'd1000));
        // still inside the single hold-off
        send_tick(mk_tick(1, MODE_SINGLE, 1, CLASS_FAST,    8'sd0, 32'd4240, 32'd500,  20'd1000));
        // hold-off ends exactly here: primed, one step
        send_tick(mk_tick(1, MODE_SINGLE, 1, CLASS_DEFAULT, 8'sd0, 32'd4240, 32'd1010, 20'd1000));
        // back to stop: perform the armed back-off step
        send_tick(mk_tick(1, MODE_STOP,   1, CLASS_DEFAULT, 8'sd0, 32'd5860, 32'd1100, 20'd1000));
        // triple one ms before the back-off hold-off ends, then right at its end
        send_tick(mk_tick(1, MODE_TRIPLE, 1, CLASS_FAST,    8'sd0, 32'd4240, 32'd1499, 20'd1000));
        send_tick(mk_tick(1, MODE_TRIPLE, 1, CLASS_FAST,    8'sd0, 32'd4240, 32'd1500, 20'd1000));
        // speed loop at the rate extremes
        send_tick(mk_tick(1, MODE_BURST,   1, CLASS_FAST, 8'sd127,  32'd0, 32'd1600, 20'd1000));
        send_tick(mk_tick(1, MODE_REVERSE, 1, CLASS_FAST, -8'sd128, 32'd0, 32'd1700, 20'd1000));
        send_tick(mk_tick(1, MODE_BURST,   1, CLASS_FAST, 8'sd0,    32'd0, 32'd1800, 20'd1000));
        // unknown modes leave the loader untouched
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_tick(mk_tick(1, 3'(m), 1, CLASS_DEFAULT, 8'sd5, 32'd0, 32'd1900, 20'd1000));
        // armed since the triple left stop
        send_tick(mk_tick(1, MODE_STOP,   1, CLASS_DEFAULT, 8'sd0, 32'd100, 32'd2100, 20'd1000));
        // unprimed single from the top of the angle range: clips high
        send_tick(mk_tick(1, MODE_SINGLE, 1, CLASS_FAST, 8'sd0, 32'h7FFF_FFFF, 32'd2600, 20'd1000));
        // back-off from the bottom of the range: clips low
        send_tick(mk_tick(1, MODE_STOP,   1, CLASS_FAST, 8'sd0, 32'h8000_0000, 32'd2700, 20'd1000));
        // friction targets: off, slow classes, zero and widest intervals
        send_tick(mk_tick(1, MODE_STOP, 0, CLASS_FAST, 8'sd0, 32'd0, 32'd2800, 20'hFFFFF));
        send_tick(mk_tick(1, MODE_STOP, 1, CLASS_15MS, 8'sd0, 32'd0, 32'd2900, 20'd0));
        send_tick(mk_tick(1, MODE_STOP, 1, CLASS_18MS, 8'sd0, 32'd0, 32'd3000, 20'hFFFFF));
        send_tick(mk_tick(1, MODE_STOP, 1, CLASS_DEFAULT, 8'sd0, 32'd0, 32'd3100, 20'hFFFFF));
        // hold-off near the top of the timeline must not wrap
        send_tick(mk_tick(1, MODE_TRIPLE, 1, CLASS_FAST, 8'sd0, 32'd0, 32'hFFFF_FF00, 20'd1000));
        send_tick(mk_tick(1, MODE_SINGLE, 1, CLASS_FAST, 8'sd0, 32'd0, 32'hFFFF_FFFF, 20'd1000));
        send_tick(mk_tick(1, MODE_SINGLE, 1, CLASS_FAST, 8'sd0, 32'd0, 32'd5,         20'd1000));
        // motors off while in burst
        send_tick(mk_tick(0, MODE_BURST, 0, CLASS_FAST, -8'sd1, 32'd0, 32'd6, 20'd1));
        settle();

        // Every register at its top value; the timeline jumps now and then so
        // the longest hold-offs still expire.
        program_regs('1);
        clock_ms = '0;
        run_random(250, 2000);
        settle();

        // Everything zero: no hold-off, no step, and a zero filter divisor
        // whenever the interval is zero as well.
        program_regs('0);
        run_random(200, 50);
        settle();

        // Short hold-offs against a fast timeline, short time constants.
        program_regs(random_cfg(60, 1000));
        run_random(300, 80);
        settle();

        // Random full-range registers; stall the result side for a long
        // stretch while ticks keep coming.
        program_regs(random_cfg(65535, 24'hFF_FFFF));
        squeeze_req = 1'b1;
        run_random(300, 3000);
        settle();

        // Back to the reset values, both sides at full rate.
        c = '{RST_SINGLE_HOLD, RST_TRIPLE_HOLD, RST_BACKOFF_HOLD, RST_FILTER_RC,
              RST_FAST_SPEED, RST_DEFAULT_SPD, RST_STEP_ANGLE, RST_RATE_SCALE};
        program_regs(c);
        calm = 1'b1;
        run_random(250, 1200);
        settle();

        $display("Covered %0d ticks and %0d result words over six register settings.",
                 ticks_sent, ledger.results_seen);
        $display("Angle shots %0d, held shots %0d, back-offs %0d, speed targets %0d,",
                 ledger.angle_shots, ledger.held_shots, ledger.backoffs,
                 ledger.speed_sets);
        $display("clipped %0d, frozen filter %0d.", ledger.clipped, ledger.frozen_filter);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d result words missing",
                     ledger.mismatches, ledger.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/sfs_pkg.sv
rtl/core/sfs_loader.sv
rtl/core/sfs_filter.sv
rtl/core/shooter_feed_sequencer.sv
test/tb_shooter_feed_sequencer.sv
